### rtl/core/plpm_pkg.sv
// Package for the piecewise linear prefix minimum block.
// Holds the field width, queue depth, command kinds and back-end states.
// No dependencies.
package plpm_pkg;

  // Width of every coordinate field on the external channels.
  localparam int unsigned FieldWidth = 32;

  // Depth of the command queue between the front and the back end.
  localparam int unsigned CmdQueueDepth = 2;

  // What the back end has to do with one command.
  typedef enum logic {
    CMD_PASS,   // emit the incoming point alone
    CMD_CROSS   // compute the crossing, maybe emit it, then emit the point
  } cmd_kind_e;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_A,
    BK_MUL_B,
    BK_ADD,
    BK_ABS,
    BK_DIV,
    BK_FIX,
    BK_EMIT_X,
    BK_EMIT_MAIN
  } back_state_e;

endpackage

### rtl/core/plpm_in_if.sv
// Input channel of the prefix minimum block: one breakpoint per beat.
// Depends on plpm_pkg for the field width.
interface plpm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [plpm_pkg::FieldWidth-1:0]  point_pos;
  logic signed [plpm_pkg::FieldWidth-1:0]  point_value;
  logic                                    start_new;

  modport source (output valid, output point_pos, output point_value, output start_new,
                  input ready);
  modport sink (input valid, input point_pos, input point_value, input start_new,
                output ready);
endinterface

### rtl/core/plpm_out_if.sv
// Output channel of the prefix minimum block: one result breakpoint per beat.
// Depends on plpm_pkg for the field width.
interface plpm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [plpm_pkg::FieldWidth-1:0]  out_pos;
  logic signed [plpm_pkg::FieldWidth-1:0]  out_value;
  logic                                    run_last;

  modport source (output valid, output out_pos, output out_value, output run_last,
                  input ready);
  modport sink (input valid, input out_pos, input out_value, input run_last,
                output ready);
endinterface

### rtl/core/plpm_front.sv
// Front end: accepts breakpoints, tracks the running minimum and queues commands.
// Depends on plpm_pkg and plpm_in_if.
module plpm_front #(
  parameter int unsigned CoordW = 32,
  localparam int unsigned CmdW  = 8 * CoordW + 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  plpm_in_if.sink         pt_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output logic [CmdW-1:0] cmd_o
);
  import plpm_pkg::*;

  typedef struct packed {
    cmd_kind_e                kind;
    logic signed [CoordW-1:0] pos;
    logic signed [CoordW-1:0] value;
    logic signed [CoordW-1:0] prev_pos;
    logic signed [CoordW-1:0] min_value;
    logic signed [CoordW-1:0] last_pos;
    logic signed [CoordW:0]   dvm;
    logic signed [CoordW:0]   dmp;
    logic signed [CoordW:0]   den;
  } cmd_t;

  logic                     have_q, have_d;
  logic signed [CoordW-1:0] prev_pos_q, prev_pos_d;
  logic signed [CoordW-1:0] prev_val_q, prev_val_d;
  logic signed [CoordW-1:0] last_pos_q, last_pos_d;
  logic signed [CoordW-1:0] last_val_q, last_val_d;

  logic signed [CoordW-1:0] p, v;
  logic signed [CoordW:0]   dvm, dmp, den;
  logic                     is_start, is_lower, do_cross, accept;
  cmd_t                     cmd;

  assign p = pt_i.point_pos[CoordW-1:0];
  assign v = pt_i.point_value[CoordW-1:0];

  assign is_start = pt_i.start_new || !have_q;
  assign is_lower = v < last_val_q;

  assign dvm = {v[CoordW-1], v} - {last_val_q[CoordW-1], last_val_q};
  assign dmp = {last_val_q[CoordW-1], last_val_q} - {prev_val_q[CoordW-1], prev_val_q};
  assign den = {v[CoordW-1], v} - {prev_val_q[CoordW-1], prev_val_q};

  // A crossing is only possible when the last output did not come from the previous point.
  assign do_cross = (prev_pos_q != last_pos_q) && (den != '0);

  always_comb begin
    cmd.kind      = (!is_start && do_cross) ? CMD_CROSS : CMD_PASS;
    cmd.pos       = p;
    cmd.value     = v;
    cmd.prev_pos  = prev_pos_q;
    cmd.min_value = last_val_q;
    cmd.last_pos  = last_pos_q;
    cmd.dvm       = dvm;
    cmd.dmp       = dmp;
    cmd.den       = den;
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = pt_i.valid && (is_start || is_lower);
  assign pt_i.ready  = cmd_ready_i;
  assign accept      = pt_i.valid && cmd_ready_i;

  always_comb begin
    have_d     = have_q;
    prev_pos_d = prev_pos_q;
    prev_val_d = prev_val_q;
    last_pos_d = last_pos_q;
    last_val_d = last_val_q;
    if (accept) begin
      have_d     = 1'b1;
      prev_pos_d = p;
      prev_val_d = v;
      if (is_start || is_lower) begin
        last_pos_d = p;
        last_val_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      prev_pos_q <= '0;
      prev_val_q <= '0;
      last_pos_q <= '0;
      last_val_q <= '0;
    end else begin
      have_q     <= have_d;
      prev_pos_q <= prev_pos_d;
      prev_val_q <= prev_val_d;
      last_pos_q <= last_pos_d;
      last_val_q <= last_val_d;
    end
  end

endmodule

### rtl/core/plpm_fifo.sv
// Small register queue with valid/ready on both sides.
// Depends on plpm_pkg only for the house import.
module plpm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  import plpm_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = cnt_q != CntW'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

### rtl/core/plpm_back.sv
// Back end: computes the crossing with a shared multiplier and a radix-4
// divider, then drives the output register. Depends on plpm_pkg and plpm_out_if.
module plpm_back #(
  parameter int unsigned CoordW = 32,
  localparam int unsigned CmdW  = 8 * CoordW + 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic [CmdW-1:0] cmd_i,
  plpm_out_if.source      res_o
);
  import plpm_pkg::*;

  typedef struct packed {
    cmd_kind_e                kind;
    logic signed [CoordW-1:0] pos;
    logic signed [CoordW-1:0] value;
    logic signed [CoordW-1:0] prev_pos;
    logic signed [CoordW-1:0] min_value;
    logic signed [CoordW-1:0] last_pos;
    logic signed [CoordW:0]   dvm;
    logic signed [CoordW:0]   dmp;
    logic signed [CoordW:0]   den;
  } cmd_t;

  // The numerator needs 2W+2 bits; the divider retires two of them per step.
  localparam int unsigned NumW  = 2 * CoordW + 2;
  localparam int unsigned CntW  = $clog2(CoordW + 1);
  localparam logic [CntW-1:0] LastStep = CntW'(CoordW);

  back_state_e              state_q, state_d;
  cmd_t                     cmd_in;
  cmd_t                     cmd_q;
  logic signed [NumW-1:0]   prod_q, acc_q, num_q;
  logic signed [NumW-1:0]   mul_res;
  logic signed [CoordW:0]   mul_a, mul_b;
  logic [NumW-1:0]          nmag_q;
  logic [CoordW-1:0]        rem_q, ud_q, quo_q;
  logic [CntW-1:0]          cnt_q;
  logic                     neg_q;

  logic [CoordW:0]          t1, t2, r1, r2;
  logic                     ge1, ge2;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_pos_q, out_val_q;
  logic                     out_last_q;

  logic                     out_free, emit_x, out_load, out_is_x;

  assign cmd_in   = cmd_i;
  assign out_free = !out_valid_q || res_o.ready;
  assign emit_x   = (quo_q != cmd_q.last_pos) && (quo_q != cmd_q.pos);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_in.kind == CMD_CROSS) ? BK_MUL_A : BK_EMIT_MAIN;
        end
      end
      BK_MUL_A: state_d = BK_MUL_B;
      BK_MUL_B: state_d = BK_ADD;
      BK_ADD:   state_d = BK_ABS;
      BK_ABS:   state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == LastStep) begin
          state_d = BK_FIX;
        end
      end
      BK_FIX:   state_d = BK_EMIT_X;
      BK_EMIT_X: begin
        if (!emit_x || out_free) begin
          state_d = BK_EMIT_MAIN;
        end
      end
      BK_EMIT_MAIN: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    out_is_x    = 1'b0;
    case (state_q)
      BK_IDLE: cmd_ready_o = 1'b1;
      BK_EMIT_X: begin
        out_load = emit_x && out_free;
        out_is_x = 1'b1;
      end
      BK_EMIT_MAIN: out_load = out_free;
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One shared multiplier, used for the two numerator products in turn.
  assign mul_a   = (state_q == BK_MUL_A) ? {cmd_q.prev_pos[CoordW-1], cmd_q.prev_pos}
                                         : {cmd_q.pos[CoordW-1], cmd_q.pos};
  assign mul_b   = (state_q == BK_MUL_A) ? cmd_q.dvm : cmd_q.dmp;
  assign mul_res = mul_a * mul_b;

  // Two restoring division steps per cycle.
  assign t1  = {rem_q, nmag_q[NumW-1]};
  assign ge1 = t1 >= {1'b0, ud_q};
  assign r1  = ge1 ? t1 - {1'b0, ud_q} : t1;
  assign t2  = {r1[CoordW-1:0], nmag_q[NumW-2]};
  assign ge2 = t2 >= {1'b0, ud_q};
  assign r2  = ge2 ? t2 - {1'b0, ud_q} : t2;

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_in;
        end
      end
      BK_MUL_A: prod_q <= mul_res;
      BK_MUL_B: begin
        acc_q  <= prod_q;
        prod_q <= mul_res;
      end
      BK_ADD: num_q <= acc_q + prod_q;
      BK_ABS: begin
        nmag_q <= num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
        neg_q  <= num_q[NumW-1] ^ cmd_q.den[CoordW];
        ud_q   <= cmd_q.den[CoordW] ? CoordW'(-cmd_q.den) : cmd_q.den[CoordW-1:0];
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      BK_DIV: begin
        rem_q  <= r2[CoordW-1:0];
        nmag_q <= nmag_q << 2;
        quo_q  <= {quo_q[CoordW-3:0], ge1, ge2};
        cnt_q  <= cnt_q + 1'b1;
      end
      BK_FIX: begin
        if (neg_q) begin
          quo_q <= -quo_q;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  // Output register: the next result is written while the current one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q  <= out_is_x ? quo_q : cmd_q.pos;
      out_val_q  <= out_is_x ? cmd_q.min_value : cmd_q.value;
      out_last_q <= !out_is_x;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_pos   = FieldWidth'(out_pos_q);
  assign res_o.out_value = FieldWidth'(out_val_q);
  assign res_o.run_last  = out_last_q;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (ud_q != '0))
    else $error("divider running with a zero divisor");

  a_cross_then_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT_X && out_load) |=> (state_q == BK_EMIT_MAIN))
    else $error("crossing result not followed by its point");

  a_fix_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FIX) |-> ($past(state_q) == BK_DIV && $past(cnt_q) == LastStep))
    else $error("quotient fixed before the division finished");
`endif

endmodule

### rtl/core/piecewise_linear_prefix_minimum_top.sv
// Top level of the piecewise linear prefix minimum block.
// Depends on plpm_pkg, plpm_in_if, plpm_out_if, plpm_front, plpm_fifo, plpm_back.
//
//   Channel   Direction  Beat payload
//   pt_i      in         point_pos, point_value, start_new
//   res_o     out        out_pos, out_value, run_last
//
// A point that emits nothing is taken by the front end and sends no command. A point
// that is emitted alone passes the back end through BK_EMIT_MAIN only. A point that
// needs the crossing goes through the two multiply steps, add, absolute value, the
// radix-4 divider retiring the 2*COORD_WIDTH+2 bit numerator, sign fix and the emits.
// Reset is asynchronous and active low; it clears the running minimum and queues.
// A stalled output holds its beat in the output register; the front end keeps
// accepting points until the two-entry command queue is full.
module piecewise_linear_prefix_minimum_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  plpm_in_if.sink    pt_i,
  plpm_out_if.source res_o
);
  import plpm_pkg::*;

  localparam int unsigned CmdW = 8 * COORD_WIDTH + 4;

  // Commands from the front end into the queue.
  logic            fq_valid, fq_ready;
  logic [CmdW-1:0] fq_data;

  // Commands from the queue into the back end.
  logic            qb_valid, qb_ready;
  logic [CmdW-1:0] qb_data;

  // The front end owns the running minimum; it decides for each point whether
  // anything is emitted and whether the back end must work out a crossing.
  plpm_front #(
    .CoordW (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_i        (pt_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_data)
  );

  // The queue lets the front end run ahead while a division is in progress.
  plpm_fifo #(
    .Width (CmdW),
    .Depth (CmdQueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  // The back end performs the arithmetic and produces one or two result beats.
  plpm_back #(
    .CoordW (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_data),
    .res_o       (res_o)
  );

endmodule

### sim/piecewise_linear_prefix_minimum_top_tb.sv
// Testbench for piecewise_linear_prefix_minimum_top: drives breakpoints, predicts the
// running-minimum breakpoints and checks every result beat against the prediction.
// Depends on plpm_pkg, plpm_in_if, plpm_out_if and the RTL below the top level.
module piecewise_linear_prefix_minimum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = plpm_pkg::FieldWidth;
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  // The tail wait and the stall watchdog are sized generously above the
  // crossing path of the back end.
  localparam int TAIL_CYCLES = 120;
  localparam int STALL_LIMIT = 4000;

  // One breakpoint of the prefix minimum, as it appears on the result channel.
  typedef struct packed {
    logic signed [W-1:0] pos;
    logic signed [W-1:0] value;
    logic                last;
  } min_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plpm_in_if  pt_bus ();
  plpm_out_if res_bus ();

  piecewise_linear_prefix_minimum_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_bus),
    .res_o  (res_bus)
  );

  always #10 clk_i = ~clk_i;

  // Breakpoints that the block still owes us, oldest first.
  min_point_t pending_min_pts[$];
  int         mismatch_count = 0;

  // Idle knobs, in percent of cycles, changed between test phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow of the block's running state.
  logic                seen_point = 1'b0;
  logic signed [W-1:0] prev_pos = '0;
  logic signed [W-1:0] prev_val = '0;
  logic signed [W-1:0] min_pos = '0;
  logic signed [W-1:0] min_val = '0;

  // Appends one owed breakpoint behind the ones already waiting.
  function automatic void owe_point(input min_point_t pt);
    pending_min_pts = {pending_min_pts, pt};
  endfunction

  // Works out what one incoming breakpoint makes the block emit. The crossing
  // numerator is formed in 128 bits so that no product can wrap, and the
  // quotient truncates toward zero just like the hardware divider.
  function automatic void predict_min_points(input logic signed [W-1:0] pos,
                                             input logic signed [W-1:0] val,
                                             input logic start);
    logic signed [127:0] p_wide, v_wide, m_wide, pp_wide, pv_wide;
    logic signed [127:0] num_wide, den_wide, quo_wide;
    logic signed [W-1:0] cross_pos;
    if (start || !seen_point) begin
      // A new function, or the very first point after reset, passes through.
      seen_point = 1'b1;
      owe_point(min_point_t'{pos: pos, value: val, last: 1'b1});
      min_pos = pos;
      min_val = val;
    end else if (val < min_val) begin
      p_wide   = pos;
      v_wide   = val;
      m_wide   = min_val;
      pp_wide  = prev_pos;
      pv_wide  = prev_val;
      den_wide = v_wide - pv_wide;
      // The crossing only exists when the previous input was not itself the
      // last emitted breakpoint.
      if (prev_pos != min_pos && den_wide != 0) begin
        num_wide  = pp_wide * (v_wide - m_wide) + p_wide * (m_wide - pv_wide);
        quo_wide  = num_wide / den_wide;
        cross_pos = quo_wide[W-1:0];
        if (cross_pos != min_pos && cross_pos != pos) begin
          owe_point(min_point_t'{pos: cross_pos, value: min_val, last: 1'b0});
        end
      end
      owe_point(min_point_t'{pos: pos, value: val, last: 1'b1});
      min_pos = pos;
      min_val = val;
    end
    prev_pos = pos;
    prev_val = val;
  endfunction

  // Presents one breakpoint and holds it until the block takes it. Called at a
  // falling edge and returns at a falling edge, so valid stays high between
  // back-to-back beats without being dropped.
  task automatic send_point(input logic signed [W-1:0] pos,
                            input logic signed [W-1:0] val,
                            input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    // The beat is never withdrawn, so the prediction can be queued now; no
    // result can come back before the beat is taken.
    predict_min_points(pos, val, start);
    pt_bus.point_pos   = pos;
    pt_bus.point_value = val;
    pt_bus.start_new   = start;
    pt_bus.valid       = 1'b1;
    do @(posedge clk_i); while (!pt_bus.ready);
    @(negedge clk_i);
  endtask

  // Lets every owed breakpoint come out, then a margin for stray extra beats.
  task automatic drain_results();
    pt_bus.valid = 1'b0;
    while (pending_min_pts.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // The first point after reset has no start flag and must still be taken as
  // a start. Then a plain crossing, a level tie, and a drop with no crossing.
  task automatic test_startup_and_basic_crossing();
    send_point(32'sd100, 32'sd50, 1'b0);   // passes through as a start
    send_point(32'sd110, 32'sd60, 1'b0);   // above the minimum, silent
    send_point(32'sd120, 32'sd20, 1'b0);   // crossing at 112, then the point
    send_point(32'sd130, 32'sd10, 1'b0);   // previous point was emitted: no crossing
    send_point(32'sd135, 32'sd10, 1'b0);   // equal to the minimum, silent
    send_point(32'sd140, 32'sd30, 1'b0);
    send_point(32'sd141, -32'sd1000, 1'b0);
  endtask

  // Crossings that collapse onto an existing breakpoint are suppressed.
  task automatic test_suppressed_crossings();
    // Negative positions truncate upward, so the crossing lands on the point.
    send_point(-32'sd20, 32'sd10, 1'b1);
    send_point(-32'sd10, 32'sd30, 1'b0);
    send_point(-32'sd9, -32'sd1000, 1'b0);
    // Going backward in position, the crossing lands on the last emitted one.
    send_point(32'sd0, 32'sd10, 1'b1);
    send_point(32'sd5, 32'sd20, 1'b0);
    send_point(-32'sd5, 32'sd0, 1'b0);
  endtask

  // Coordinates at the ends of the range stress the wide products.
  task automatic test_coordinate_extremes();
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    send_point(32'sd0, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, 32'sd0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b0);  // equal to the minimum, silent
  endtask

  // A start flag restarts the minimum even above the current level.
  task automatic test_restart_above_minimum();
    send_point(32'sd7, -32'sd5, 1'b1);
    send_point(32'sd9, COORD_MAX, 1'b1);
    send_point(32'sd12, 32'sd3, 1'b0);
  endtask

  // Mostly well-formed functions with random content: ascending positions and
  // values drifting downward so that runs of emitted points get long. About
  // 15 percent of the draws are a single fully random point, ordered or not, flagged or not.
  task automatic test_random_curves(input int idle_pct, input int stall_pct,
                                    input int n_items);
    int     sent;
    int     len;
    logic   wide;
    longint step_max;
    longint pos_l;
    longint val_l;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_point($urandom, $urandom, $urandom_range(7) == 0);
        sent++;
      end else begin
        len      = $urandom_range(12, 1);
        wide     = ($urandom_range(3) == 0);
        step_max = wide ? 64'sd100000000 : 64'sd16;
        if (wide) begin
          pos_l = longint'($signed($urandom));
          if (pos_l > longint'(COORD_MAX) - len * step_max) pos_l -= len * step_max;
        end else begin
          pos_l = longint'($urandom_range(2000)) - 1000;
        end
        for (int k = 0; k < len; k++) begin
          if (k > 0) pos_l += longint'($urandom_range(32'(step_max)));
          if (wide) val_l = longint'($signed($urandom));
          else val_l = longint'($urandom_range(600)) - 300 - k * 40;
          // Now and then a function begins without its start flag.
          send_point(pos_l[W-1:0], val_l[W-1:0], k == 0 && $urandom_range(9) != 0);
        end
        sent += len;
      end
    end
    drain_results();
  endtask

  // The receiver stalls at random; the knob is read every cycle.
  always @(negedge clk_i) begin
    res_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result beat is matched against the oldest owed breakpoint.
  always @(posedge clk_i) begin
    min_point_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_min_pts.size() == 0) begin
        $error("unexpected result beat: out_pos %0d out_value %0d run_last %0b",
               res_bus.out_pos, res_bus.out_value, res_bus.run_last);
        mismatch_count++;
      end else begin
        want = pending_min_pts.pop_front();
        if (res_bus.out_pos !== want.pos) begin
          $error("out_pos: expected %0d, got %0d", want.pos, res_bus.out_pos);
          mismatch_count++;
        end
        if (res_bus.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, res_bus.out_value);
          mismatch_count++;
        end
        if (res_bus.run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, res_bus.run_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat on either channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    pt_bus.valid       = 1'b0;
    pt_bus.point_pos   = '0;
    pt_bus.point_value = '0;
    pt_bus.start_new   = 1'b0;
    res_bus.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part runs with no idling on either side.
    test_startup_and_basic_crossing();
    test_suppressed_crossings();
    test_coordinate_extremes();
    test_restart_above_minimum();
    drain_results();

    // Random part, one phase per idling pattern.
    test_random_curves(0, 0, 320);
    test_random_curves(47, 0, 320);
    test_random_curves(0, 47, 320);
    test_random_curves(35, 35, 320);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/plpm_pkg.sv
rtl/core/plpm_in_if.sv
rtl/core/plpm_out_if.sv
rtl/core/plpm_front.sv
rtl/core/plpm_fifo.sv
rtl/core/plpm_back.sv
rtl/core/piecewise_linear_prefix_minimum_top.sv
sim/piecewise_linear_prefix_minimum_top_tb.sv
